// ----- src/mct_pkg.sv -----
// Package for the match countdown timer control block.
// Holds the item and state types, the mode codes, the timing constants and
// the 24-bit saturation helpers. Depends on nothing.
package mct_pkg;

	localparam logic signed [23:0] MATCH_TIME       = 24'sd120000;
	localparam logic [3:0]         COUNTDOWN_LEDS   = 4'd5;
	localparam logic [9:0]         TICKS_PER_SECOND = 10'd1000;

	localparam logic [3:0]  COUNTDOWN_START = COUNTDOWN_LEDS - 4'd1;
	localparam logic [23:0] ELAPSED_MAX     = 24'hFF_FFFF;
	localparam logic [9:0]  SECTICK_MAX     = 10'h3FF;

	localparam logic signed [25:0] MS_ADD30 = 26'sd30000;
	localparam logic signed [25:0] MS_ADD60 = 26'sd60000;
	localparam logic signed [25:0] MS_SUB15 = -26'sd15000;
	localparam logic signed [25:0] S24_MAX  = 26'sd8388607;
	localparam logic signed [25:0] S24_MIN  = -26'sd8388608;

	typedef enum logic [1:0] {
		MODE_PAUSED    = 2'd0,
		MODE_COUNTDOWN = 2'd1,
		MODE_RUNNING   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		LAMP_CLEARED = 2'd0,
		LAMP_COUNT   = 2'd1,
		LAMP_GO      = 2'd2
	} lamp_t;

	typedef struct packed {
		logic start_press;
		logic ir_trigger;
		logic resume_press;
		logic pause_press;
		logic add_thirty_press;
		logic add_sixty_press;
		logic sub_fifteen_press;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         timer_mode;
		logic signed [23:0] display_ms;
		logic [3:0]         led_level;
		logic [1:0]         led_mode;
	} out_item_t;

	typedef struct packed {
		mode_t              mode;
		logic signed [23:0] target;
		logic [23:0]        elapsed;
		logic [9:0]         sec_ticks;
		logic [3:0]         countdown;
		lamp_t              lamp;
	} state_t;

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		logic signed [23:0] r;
		if (v > S24_MAX) begin
			r = S24_MAX[23:0];
		end else if (v < S24_MIN) begin
			r = S24_MIN[23:0];
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	function automatic logic signed [23:0] add_sat(input logic signed [23:0] t,
			input logic signed [25:0] d);
		logic signed [25:0] s;
		s = $signed({{2{t[23]}}, t}) + d;
		return sat24(s);
	endfunction

endpackage

// ----- src/mct_in_if.sv -----
// Input channel of the match countdown timer control block.
// Carries valid, ready and one tick item; depends on mct_pkg.
interface mct_in_if import mct_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/mct_out_if.sv -----
// Result channel of the match countdown timer control block.
// Carries valid, ready and one result item; depends on mct_pkg.
interface mct_out_if import mct_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- src/mct_step.sv -----
// Next-state and result logic for one millisecond tick of the timer control.
// Purely combinational; depends on mct_pkg.
module mct_step import mct_pkg::*; (
	input  in_item_t  item,
	input  state_t    cur,
	output state_t    nxt,
	output out_item_t res
);

	logic signed [25:0] remain;
	logic signed [25:0] remain_end;

	always_comb begin
		nxt = cur;

		if (cur.mode == MODE_RUNNING && cur.elapsed != ELAPSED_MAX) begin
			nxt.elapsed = cur.elapsed + 24'd1;
		end
		if (cur.mode == MODE_COUNTDOWN && cur.sec_ticks != SECTICK_MAX) begin
			nxt.sec_ticks = cur.sec_ticks + 10'd1;
		end

		remain = $signed({{2{cur.target[23]}}, cur.target}) - $signed({2'b00, nxt.elapsed});

		unique case (cur.mode)
			MODE_PAUSED: begin
				if (item.start_press || item.ir_trigger) begin
					nxt.mode      = MODE_COUNTDOWN;
					nxt.sec_ticks = '0;
					nxt.countdown = COUNTDOWN_START;
				end else if (item.resume_press) begin
					nxt.mode    = MODE_RUNNING;
					nxt.elapsed = '0;
				end
			end
			MODE_COUNTDOWN: begin
				if (item.pause_press) begin
					nxt.mode = MODE_PAUSED;
					nxt.lamp = LAMP_CLEARED;
				end else if (cur.countdown == 4'd0) begin
					nxt.mode    = MODE_RUNNING;
					nxt.lamp    = LAMP_GO;
					nxt.elapsed = '0;
				end
			end
			MODE_RUNNING: begin
				if (item.pause_press || remain <= 26'sd0) begin
					nxt.mode   = MODE_PAUSED;
					nxt.lamp   = LAMP_CLEARED;
					nxt.target = sat24(remain);
				end
			end
			default: begin
				nxt.mode = cur.mode;
			end
		endcase

		if (nxt.mode == MODE_COUNTDOWN) begin
			if (nxt.sec_ticks >= TICKS_PER_SECOND) begin
				if (nxt.countdown != 4'd0) begin
					nxt.countdown = nxt.countdown - 4'd1;
				end
				nxt.sec_ticks = '0;
			end
			nxt.lamp = LAMP_COUNT;
		end

		if (item.add_thirty_press) begin
			nxt.target = add_sat(nxt.target, MS_ADD30);
		end
		if (item.add_sixty_press) begin
			nxt.target = add_sat(nxt.target, MS_ADD60);
		end
		if (item.sub_fifteen_press) begin
			nxt.target = add_sat(nxt.target, MS_SUB15);
		end

		remain_end = $signed({{2{nxt.target[23]}}, nxt.target})
			- $signed({2'b00, nxt.elapsed});

		res.timer_mode = nxt.mode;
		res.display_ms = (nxt.mode == MODE_RUNNING) ? sat24(remain_end) : nxt.target;
		res.led_level  = nxt.countdown;
		res.led_mode   = nxt.lamp;
	end

endmodule

// ----- src/match_countdown_timer_control_top.sv -----
// Top level of the match countdown timer control block.
// Holds the input register, the timer state and the result register around
// mct_step; depends on mct_pkg, mct_in_if and mct_out_if.

// Each accepted item is one millisecond tick and yields exactly one result item. The block
// takes one item per clock cycle while results are taken; an item waits in the input register,
// then its result is loaded into the result register and presented from there.
// The timer state is updated at the edge that loads the result register. A
// stalled result holds both registers, so up to two items are buffered before cmd.ready
// drops. There are no configuration registers; the match time, the LED count and the ticks
// per second are package constants.
module match_countdown_timer_control_top import mct_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	mct_in_if.sink   cmd,
	mct_out_if.source res
);

	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	state_t    state_q;
	state_t    state_nxt;
	out_item_t res_nxt;
	logic      advance;

	assign advance   = !valid_s2 || res.ready;
	assign cmd.ready = !valid_s1 || advance;

	mct_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q.mode      <= MODE_PAUSED;
			state_q.target    <= MATCH_TIME;
			state_q.elapsed   <= '0;
			state_q.sec_ticks <= '0;
			state_q.countdown <= COUNTDOWN_LEDS;
			state_q.lamp      <= LAMP_CLEARED;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1 <= cmd.data;
		end
		if (advance && valid_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign res.valid = valid_s2;
	assign res.data  = res_s2;

`ifndef ASSERT_OFF
	a_lamp_in_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_COUNTDOWN |-> state_q.lamp == LAMP_COUNT)
		else $error("LED mode is not countdown while counting down");

	a_sec_ticks_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_COUNTDOWN |-> state_q.sec_ticks < TICKS_PER_SECOND)
		else $error("Second tick counter passed its wrap point");

	a_no_run_to_countdown: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mode == MODE_RUNNING |=> state_q.mode != MODE_COUNTDOWN)
		else $error("Running mode went straight to the start countdown");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(state_q))
		else $error("Timer state changed without an item moving to the result register");
`endif

endmodule

// ----- tb/sv/tb_match_countdown_timer_control_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for match_countdown_timer_control_top: drives button ticks
// through the item channels and checks every result against a tick-accurate timer model.
// Depends on mct_pkg, mct_in_if, mct_out_if and the top level of the block.
module tb_match_countdown_timer_control_top;
	import mct_pkg::*;

	localparam logic [6:0] P_NONE   = 7'b000_0000;
	localparam logic [6:0] P_START  = 7'b100_0000;
	localparam logic [6:0] P_IR     = 7'b010_0000;
	localparam logic [6:0] P_RESUME = 7'b001_0000;
	localparam logic [6:0] P_PAUSE  = 7'b000_1000;
	localparam logic [6:0] P_ADD30  = 7'b000_0100;
	localparam logic [6:0] P_ADD60  = 7'b000_0010;
	localparam logic [6:0] P_SUB15  = 7'b000_0001;
	localparam logic [6:0] P_ALL    = 7'b111_1111;

	localparam logic signed [23:0] TARGET_TOP    = S24_MAX[23:0];
	localparam logic signed [23:0] TARGET_BOTTOM = S24_MIN[23:0];
	localparam int RANDOM_PULSE_ITEMS = 650;
	localparam int MAX_FULL_COUNTDOWNS = 4;

	logic clk;
	logic arst_n;

	mct_in_if  cmd_if();
	mct_out_if res_if();

	match_countdown_timer_control_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	mode_t              tm_mode;
	logic signed [23:0] tm_target;
	logic [23:0]        tm_elapsed;
	logic [9:0]         tm_sec;
	logic [3:0]         tm_count;
	lamp_t              tm_lamp;

	out_item_t   pending_readouts[$];
	out_item_t   want;
	int unsigned fail_count;
	int unsigned pulse_ticks;
	int          burst_left;
	int unsigned ready_phase;
	int unsigned ready_style;

	always #5 clk = ~clk;

	initial begin
		#40_000_000;
		$display("TB_ERROR");
		$finish;
	end

	always @(posedge clk) begin
		ready_phase <= ready_phase + 1;
		if (ready_phase[6:0] == 7'd0) begin
			ready_style <= $urandom_range(3);
		end
		case (ready_style)
			0: res_if.ready <= 1'b1;
			1: res_if.ready <= ($urandom_range(1) == 0);
			2: res_if.ready <= (ready_phase[1:0] == 2'd0);
			default: res_if.ready <= ($urandom_range(99) < 85);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && res_if.valid && res_if.ready) begin
			if (pending_readouts.size() == 0) begin
				fail_count++;
				if (fail_count <= 10) begin
					$display("unexpected result: mode %0d display %0d leds %0d lamp %0d",
						res_if.data.timer_mode, res_if.data.display_ms,
						res_if.data.led_level, res_if.data.led_mode);
				end
			end else begin
				want = pending_readouts.pop_front();
				if (res_if.data.timer_mode !== want.timer_mode ||
						res_if.data.display_ms !== want.display_ms ||
						res_if.data.led_level !== want.led_level ||
						res_if.data.led_mode !== want.led_mode) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display({"mismatch at %0t: mode %0d/%0d display %0d/%0d ",
							"leds %0d/%0d lamp %0d/%0d (exp/got)"},
							$realtime, want.timer_mode, res_if.data.timer_mode,
							want.display_ms, res_if.data.display_ms,
							want.led_level, res_if.data.led_level,
							want.led_mode, res_if.data.led_mode);
					end
				end
			end
		end
	end

	function automatic logic signed [23:0] clamp24(input longint v);
		logic signed [23:0] r;
		if (v > longint'(S24_MAX)) begin
			r = TARGET_TOP;
		end else if (v < longint'(S24_MIN)) begin
			r = TARGET_BOTTOM;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	task automatic reset_timer_model();
		tm_mode = MODE_PAUSED;
		tm_target = MATCH_TIME;
		tm_elapsed = '0;
		tm_sec = '0;
		tm_count = COUNTDOWN_LEDS;
		tm_lamp = LAMP_CLEARED;
	endtask

	function automatic longint remaining_ms();
		return longint'(tm_target) - longint'(tm_elapsed);
	endfunction

	function automatic out_item_t advance_timer(input in_item_t it);
		out_item_t r;
		if (tm_mode == MODE_RUNNING && tm_elapsed < ELAPSED_MAX) begin
			tm_elapsed = tm_elapsed + 24'd1;
		end
		if (tm_mode == MODE_COUNTDOWN && tm_sec < SECTICK_MAX) begin
			tm_sec = tm_sec + 10'd1;
		end
		case (tm_mode)
			MODE_PAUSED: begin
				if (it.start_press || it.ir_trigger) begin
					tm_mode = MODE_COUNTDOWN;
					tm_sec = '0;
					tm_count = COUNTDOWN_START;
				end else if (it.resume_press) begin
					tm_mode = MODE_RUNNING;
					tm_elapsed = '0;
				end
			end
			MODE_COUNTDOWN: begin
				if (it.pause_press) begin
					tm_mode = MODE_PAUSED;
					tm_lamp = LAMP_CLEARED;
				end else if (tm_count == 4'd0) begin
					tm_mode = MODE_RUNNING;
					tm_lamp = LAMP_GO;
					tm_elapsed = '0;
				end
			end
			default: begin
				if (it.pause_press || remaining_ms() <= 0) begin
					tm_mode = MODE_PAUSED;
					tm_lamp = LAMP_CLEARED;
					tm_target = clamp24(remaining_ms());
				end
			end
		endcase
		if (tm_mode == MODE_COUNTDOWN) begin
			if (tm_sec >= TICKS_PER_SECOND) begin
				if (tm_count > 4'd0) begin
					tm_count = tm_count - 4'd1;
				end
				tm_sec = '0;
			end
			tm_lamp = LAMP_COUNT;
		end
		if (it.add_thirty_press) begin
			tm_target = clamp24(longint'(tm_target) + longint'(MS_ADD30));
		end
		if (it.add_sixty_press) begin
			tm_target = clamp24(longint'(tm_target) + longint'(MS_ADD60));
		end
		if (it.sub_fifteen_press) begin
			tm_target = clamp24(longint'(tm_target) + longint'(MS_SUB15));
		end
		r.timer_mode = tm_mode;
		r.display_ms = (tm_mode == MODE_RUNNING) ? clamp24(remaining_ms()) : tm_target;
		r.led_level = tm_count;
		r.led_mode = tm_lamp;
		return r;
	endfunction

	task automatic send_tick(input logic [6:0] bits);
		in_item_t it;
		it = in_item_t'(bits);
		if (burst_left <= 0) begin
			if ($urandom_range(3) != 0) begin
				cmd_if.valid <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 400) :
				$urandom_range(1, 24);
		end
		burst_left--;
		cmd_if.valid <= 1'b1;
		cmd_if.data <= it;
		@(posedge clk);
		while (!cmd_if.ready) @(posedge clk);
		pending_readouts.push_back(advance_timer(it));
		if (bits != P_NONE) begin
			pulse_ticks++;
		end
	endtask

	function automatic logic [6:0] adjust_bits();
		return {4'b0000, 3'($urandom_range(1, 7))};
	endfunction

	function automatic logic [6:0] sparse_bits(input int one_in);
		logic [6:0] b;
		b = P_NONE;
		if ($urandom_range(one_in - 1) == 0) begin
			b = adjust_bits();
			if ($urandom_range(3) == 0) begin
				b = b | ($urandom_range(1) ? P_START : P_IR);
			end
		end
		return b;
	endfunction

	function automatic logic [6:0] noise_bits();
		logic [6:0] b;
		b[6] = ($urandom_range(99) < 15);
		b[5] = ($urandom_range(99) < 15);
		b[4] = ($urandom_range(99) < 15);
		b[3] = ($urandom_range(99) < 15);
		b[2] = ($urandom_range(99) < 10);
		b[1] = ($urandom_range(99) < 10);
		b[0] = ($urandom_range(99) < 60);
		return b;
	endfunction

	task automatic make_paused();
		if (tm_mode != MODE_PAUSED) begin
			send_tick(P_PAUSE);
		end
	endtask

	task automatic test_button_pulses();
		send_tick(P_NONE);
		send_tick(P_ADD30);
		send_tick(P_ADD60);
		send_tick(P_SUB15);
		send_tick(P_ADD30 | P_ADD60 | P_SUB15);
		send_tick(P_PAUSE);
		send_tick(P_RESUME);
		send_tick(P_START | P_IR);
		send_tick(P_ADD30);
		send_tick(P_NONE);
		send_tick(P_RESUME | P_SUB15);
		send_tick(P_PAUSE);
		send_tick(P_IR);
		send_tick(P_RESUME | P_SUB15);
		send_tick(P_START);
		send_tick(P_PAUSE);
		send_tick(P_START | P_RESUME);
		send_tick(P_PAUSE | P_ADD60);
		send_tick(P_RESUME | P_PAUSE);
		send_tick(P_PAUSE);
		send_tick(P_ALL);
		send_tick(P_ALL);
		send_tick(P_ALL);
		send_tick(P_PAUSE);
	endtask

	task automatic test_led_countdown();
		make_paused();
		send_tick(P_START);
		while (tm_mode == MODE_COUNTDOWN && tm_count != 4'd0) send_tick(P_NONE);
		send_tick(P_PAUSE);
		send_tick(P_IR | P_ADD30);
		while (tm_mode == MODE_COUNTDOWN) send_tick(P_NONE);
		repeat (5) send_tick(P_NONE);
		send_tick(P_PAUSE);
	endtask

	task automatic test_time_expiry();
		make_paused();
		while (tm_target > 24'sd15000) send_tick(P_SUB15);
		send_tick(P_RESUME);
		while (tm_mode == MODE_RUNNING) send_tick(P_NONE);
		send_tick(P_SUB15);
		send_tick(P_SUB15);
		send_tick(P_RESUME);
		while (tm_mode == MODE_RUNNING) send_tick(P_NONE);
		send_tick(P_ADD60);
		send_tick(P_RESUME | P_ADD30);
		repeat (3) send_tick(P_NONE);
		send_tick(P_SUB15);
		send_tick(P_SUB15);
		send_tick(P_SUB15);
		while (tm_mode == MODE_RUNNING) send_tick(P_NONE);
	endtask

	task automatic test_target_limits();
		make_paused();
		while (tm_target != TARGET_TOP) send_tick(P_ADD30 | P_ADD60);
		send_tick(P_ADD60);
		send_tick(P_RESUME | P_ADD30);
		repeat (3) send_tick(P_NONE);
		send_tick(P_PAUSE);
		while (tm_target != TARGET_BOTTOM) send_tick(P_SUB15);
		send_tick(P_SUB15);
		send_tick(P_RESUME | P_SUB15);
		send_tick(P_NONE);
		send_tick(P_ADD60);
		send_tick(P_ADD30 | P_ADD60);
		send_tick(P_SUB15 | P_ADD60);
	endtask

	task automatic test_random_sessions();
		int unsigned base;
		int unsigned full_runs;
		int unsigned n;
		int unsigned kind;
		base = pulse_ticks;
		full_runs = 0;
		while (pulse_ticks - base < RANDOM_PULSE_ITEMS) begin
			kind = $urandom_range(9);
			if (kind == 8 && full_runs >= MAX_FULL_COUNTDOWNS) begin
				kind = 0;
			end
			if (kind >= 4) begin
				make_paused();
			end
			case (kind)
				4, 5: begin
					send_tick(P_RESUME | ($urandom_range(1) ? adjust_bits() : P_NONE));
					n = $urandom_range(5, 60);
					while (n > 0 && tm_mode == MODE_RUNNING) begin
						send_tick(sparse_bits(20));
						n--;
					end
					if (tm_mode == MODE_RUNNING) begin
						send_tick(P_PAUSE | ($urandom_range(1) ? adjust_bits() : P_NONE));
					end
				end
				6, 7: begin
					send_tick(($urandom_range(1) ? P_START : P_IR) |
						($urandom_range(1) ? P_RESUME : P_NONE));
					repeat ($urandom_range(20, 200)) send_tick(sparse_bits(20));
					send_tick(P_PAUSE | ($urandom_range(1) ? adjust_bits() : P_NONE));
				end
				8: begin
					full_runs++;
					send_tick($urandom_range(1) ? P_START : P_IR);
					while (tm_mode == MODE_COUNTDOWN) send_tick(sparse_bits(300));
					repeat ($urandom_range(10, 100)) send_tick(sparse_bits(20));
					make_paused();
				end
				9: begin
					while (tm_target > 0) send_tick(P_SUB15 | ($urandom_range(3) ?
						P_NONE : P_SUB15));
					send_tick(P_RESUME);
					while (tm_mode == MODE_RUNNING) send_tick(P_NONE);
					send_tick(P_ADD60 | P_ADD30);
				end
				default: begin
					repeat ($urandom_range(10, 40)) send_tick(noise_bits());
				end
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.data = '0;
		res_if.ready = 1'b0;
		fail_count = 0;
		pulse_ticks = 0;
		burst_left = 0;
		ready_phase = 0;
		ready_style = 0;
		reset_timer_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_button_pulses();
		test_led_countdown();
		test_time_expiry();
		test_target_limits();
		test_random_sessions();

		cmd_if.valid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (pending_readouts.size() != 0) begin
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
